/* rtl/lsp_pkg.sv */
// Shared types, constants and tables for the least-squares polynomial fit block.
package lsp_pkg;

    localparam int DEF_MAX_DEGREE = 2;
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 12;

    localparam int FIELD_BITS  = 12;
    localparam int VALUE_BITS  = 64;
    localparam int Q_FRAC_BITS = 32;

    localparam int PERM_COUNT = 24;
    localparam int PERM_SIZE  = 4;

    localparam logic       CFG_DEGREE   = 1'b0;
    localparam logic       CFG_SWAP     = 1'b1;
    localparam logic [1:0] DEGREE_RESET = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FEW      = 2'd1,
        ST_SINGULAR = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_fit_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_PS,
        S_ACC_P,
        S_SOLVE,
        S_DET_START,
        S_PERM,
        S_ROW,
        S_MUL,
        S_DET_END,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] value;
    } t_qdiv_res;

    function automatic logic [7:0] perm_pack(int a, int b, int c, int d);
        return {2'(d), 2'(c), 2'(b), 2'(a)};
    endfunction

    // Column of each row for all permutations of four, row 0 in the low bits.
    localparam logic [7:0] PERM_COLS [PERM_COUNT] = '{
        perm_pack(0, 1, 2, 3), perm_pack(0, 1, 3, 2), perm_pack(0, 2, 1, 3),
        perm_pack(0, 2, 3, 1), perm_pack(0, 3, 1, 2), perm_pack(0, 3, 2, 1),
        perm_pack(1, 0, 2, 3), perm_pack(1, 0, 3, 2), perm_pack(1, 2, 0, 3),
        perm_pack(1, 2, 3, 0), perm_pack(1, 3, 0, 2), perm_pack(1, 3, 2, 0),
        perm_pack(2, 0, 1, 3), perm_pack(2, 0, 3, 1), perm_pack(2, 1, 0, 3),
        perm_pack(2, 1, 3, 0), perm_pack(2, 3, 0, 1), perm_pack(2, 3, 1, 0),
        perm_pack(3, 0, 1, 2), perm_pack(3, 0, 2, 1), perm_pack(3, 1, 0, 2),
        perm_pack(3, 1, 2, 0), perm_pack(3, 2, 0, 1), perm_pack(3, 2, 1, 0)
    };

    localparam logic [PERM_COUNT-1:0] PERM_ODD = 24'b011001_100110_011001_100110;

endpackage

/* rtl/lsp_qdiv.sv */
// Restoring divider giving a rounded, saturated Q32.32 quotient of two wide integers.
module lsp_qdiv
    import lsp_pkg::*;
#(
    parameter int BIG_W = VALUE_BITS * (DEF_MAX_DEGREE + 1) + 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [BIG_W-1:0] i_num,
    input  logic [BIG_W-1:0] i_den,
    output t_qdiv_res        o_res
);

    localparam int DW    = BIG_W + VALUE_BITS + 2;
    localparam int QB    = VALUE_BITS + 1;
    localparam int CNT_W = $clog2(QB);

    logic                  r_active;
    logic                  r_first;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic [DW-1:0]         r_rem;
    logic [DW-1:0]         r_dsh;
    logic [QB-2:0]         r_q;
    logic                  r_done;
    logic [VALUE_BITS-1:0] r_val;

    logic [BIG_W-1:0]      num_abs;
    logic [BIG_W-1:0]      den_abs;
    logic                  ge;
    logic [QB-1:0]         q_fin;
    logic [VALUE_BITS-1:0] sat_val;
    logic [VALUE_BITS-1:0] fin_val;

    assign num_abs = i_num[BIG_W-1] ? (-i_num) : i_num;
    assign den_abs = i_den[BIG_W-1] ? (-i_den) : i_den;
    assign ge      = r_rem >= r_dsh;
    assign q_fin   = {r_q, ge};
    assign sat_val = r_neg ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};

    always_comb begin
        if (!r_neg) begin
            fin_val = (q_fin[QB-1] || q_fin[QB-2]) ? sat_val : q_fin[VALUE_BITS-1:0];
        end else begin
            fin_val = (q_fin[QB-1] || (q_fin[QB-2] && (|q_fin[QB-3:0]))) ?
                      sat_val : (-q_fin[VALUE_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_first  <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_first  <= 1'b1;
                r_neg    <= i_num[BIG_W-1] ^ i_den[BIG_W-1];
                r_rem    <= (DW'(num_abs) << (Q_FRAC_BITS + 1)) + DW'(den_abs);
                r_dsh    <= DW'(den_abs) << (QB + 1);
                r_q      <= '0;
            end else if (r_active && r_first) begin
                if (ge) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                    r_val    <= sat_val;
                end else begin
                    r_first <= 1'b0;
                    r_dsh   <= r_dsh >> 1;
                    r_cnt   <= CNT_W'(QB - 1);
                end
            end else if (r_active) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= q_fin[QB-2:0];
                r_dsh <= r_dsh >> 1;
                if (r_cnt == '0) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                    r_val    <= fin_val;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_val;

endmodule

/* rtl/least_squares_polyfit.sv */
// Top level: power-sum accumulation, Cramer determinant sequencer and coefficient output.
// A point is taken in S_IDLE and accumulated in S_ACC_PS and S_ACC_P, one pair per power sum,
// through one shared 64 by COORD_BITS multiplier; no new point is taken until it is done.
// A last point then starts the solve: each of the d+2 determinants walks 24 permutations and
// runs (d+1) bit-serial 64-bit multiplies per valid one; the later ones are divided by the first.
// The d+1 coefficients then leave on the output stream.
// Reset (synchronous, active low) clears all sums, the count and the flags; degree resets to 2.
module least_squares_polyfit
    import lsp_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // coord_first, coord_second
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // coeff_index, coeff_value, zero fill
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // fit_status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    localparam int NCOEF  = MAX_DEGREE + 1;
    localparam int NPOW   = 2 * MAX_DEGREE + 1;
    localparam int PS_AW  = $clog2(NPOW);
    localparam int CR_AW  = $clog2(NCOEF);
    localparam int ROW_W  = $clog2(NCOEF + 1);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int BIG_W  = VALUE_BITS * NCOEF + 6;
    localparam int PERM_W = $clog2(PERM_COUNT);
    localparam int BIT_W  = $clog2(VALUE_BITS);

    t_state                  r_state, n_state;
    logic [1:0]              r_degree;
    logic                    r_swap;
    logic [VALUE_BITS-1:0]   r_psum [NPOW];
    logic [VALUE_BITS-1:0]   n_psum [NPOW];
    logic [VALUE_BITS-1:0]   r_csum [NCOEF];
    logic [VALUE_BITS-1:0]   n_csum [NCOEF];
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_ovf, n_ovf;
    logic signed [COORD_BITS-1:0] r_x, n_x, r_y, n_y;
    logic                    r_last, n_last;
    logic [PS_AW-1:0]        r_k, n_k;
    logic [VALUE_BITS-1:0]   r_p, n_p;
    logic [VALUE_BITS-1:0]   r_mres, n_mres;
    logic [ROW_W-1:0]        r_m, n_m;
    logic [ROW_W-1:0]        r_pass, n_pass;
    logic [PERM_W-1:0]       r_perm, n_perm;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [BIT_W-1:0]        r_bit, n_bit;
    logic [VALUE_BITS-1:0]   r_mop, n_mop;
    logic [BIG_W-1:0]        r_macc, n_macc;
    logic [BIG_W-1:0]        r_prod, n_prod;
    logic [BIG_W-1:0]        r_det, n_det;
    logic [BIG_W-1:0]        r_den, n_den;
    logic [VALUE_BITS-1:0]   r_coef [NCOEF];
    logic                    r_zero, n_zero;
    t_fit_status             r_status, n_status;
    logic [ROW_W-1:0]        r_eidx, n_eidx;
    logic                    r_out_valid, n_out_valid;
    logic [71:0]             r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;
    logic [1:0]              r_out_user, n_out_user;

    logic                    in_acc;
    logic                    cnt_room;
    logic signed [COORD_BITS-1:0] in_first, in_second;
    logic signed [COORD_BITS-1:0] mul_b;
    logic signed [VALUE_BITS+COORD_BITS-1:0] mul_full;
    logic [1:0]              d_eff;
    logic                    few;
    logic [1:0]              col;
    logic [PS_AW-1:0]        ps_addr;
    logic [CR_AW-1:0]        cr_addr;
    logic [VALUE_BITS-1:0]   entry;
    logic                    perm_ok;
    logic                    perm_end;
    logic                    row_end;
    logic [BIG_W-1:0]        mul_add;
    logic [ROW_W-1:0]        pass_m1;
    logic                    emit_last;
    logic                    out_load;
    logic                    div_start;
    logic                    coef_we;
    t_qdiv_res               div_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cnt_room      = r_count < CNT_W'(MAX_POINTS);
    assign in_first      = s_axis_tdata[COORD_BITS-1:0];
    assign in_second     = s_axis_tdata[FIELD_BITS +: COORD_BITS];

    assign mul_b    = (r_state == S_ACC_PS) ? r_y : r_x;
    assign mul_full = $signed(r_p) * mul_b;

    always_comb begin
        if (r_degree == 2'd0) begin
            d_eff = 2'd1;
        end else if (r_degree > 2'(MAX_DEGREE)) begin
            d_eff = 2'(MAX_DEGREE);
        end else begin
            d_eff = r_degree;
        end
    end
    assign few = r_count <= CNT_W'(d_eff);

    assign col     = PERM_COLS[r_perm][2*r_row +: 2];
    assign pass_m1 = r_pass - ROW_W'(1);
    assign ps_addr = (r_state == S_ACC_PS || r_state == S_ACC_P) ?
                     r_k : (PS_AW'(r_row) + PS_AW'(col));
    assign cr_addr = (r_state == S_ACC_P) ? r_k[CR_AW-1:0] : r_row[CR_AW-1:0];
    assign entry   = ((r_pass != '0) && (ROW_W'(col) == pass_m1)) ?
                     r_csum[cr_addr] : r_psum[ps_addr];

    always_comb begin
        perm_ok = 1'b1;
        for (int r = 0; r < PERM_SIZE; r++) begin
            if ((r >= int'(r_m)) && (int'(PERM_COLS[r_perm][2*r +: 2]) != r)) begin
                perm_ok = 1'b0;
            end
        end
    end
    assign perm_end  = r_perm == PERM_W'(PERM_COUNT - 1);
    assign row_end   = r_row == r_m;
    assign mul_add   = !r_mop[r_bit] ? '0 :
                       (r_bit == BIT_W'(VALUE_BITS - 1)) ? (-r_prod) : r_prod;
    assign emit_last = r_eidx == (r_m - ROW_W'(1));
    assign out_load  = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);
    assign div_start = (r_state == S_DET_END) && (r_pass != '0);
    assign coef_we   = (r_state == S_DIV) && div_res.done;

    lsp_qdiv #(
        .BIG_W (BIG_W)
    ) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_det),
        .i_den   (r_den),
        .o_res   (div_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (cnt_room) begin
                        n_state = S_ACC_PS;
                    end else if (s_axis_tlast) begin
                        n_state = S_SOLVE;
                    end
                end
            end
            S_ACC_PS: n_state = S_ACC_P;
            S_ACC_P: begin
                if (r_k == PS_AW'(NPOW - 1)) begin
                    n_state = r_last ? S_SOLVE : S_IDLE;
                end else begin
                    n_state = S_ACC_PS;
                end
            end
            S_SOLVE:     n_state = few ? S_EMIT : S_DET_START;
            S_DET_START: n_state = S_PERM;
            S_PERM: begin
                if (perm_ok) begin
                    n_state = S_ROW;
                end else if (perm_end) begin
                    n_state = S_DET_END;
                end
            end
            S_ROW: begin
                if (!row_end) begin
                    n_state = S_MUL;
                end else begin
                    n_state = perm_end ? S_DET_END : S_PERM;
                end
            end
            S_MUL: begin
                if (r_bit == '0) begin
                    n_state = S_ROW;
                end
            end
            S_DET_END: begin
                if (r_pass != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = (r_det == '0) ? S_EMIT : S_DET_START;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = (r_pass == r_m) ? S_EMIT : S_DET_START;
                end
            end
            S_EMIT: begin
                if (out_load && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_psum      = r_psum;
        n_csum      = r_csum;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_x         = r_x;
        n_y         = r_y;
        n_last      = r_last;
        n_k         = r_k;
        n_p         = r_p;
        n_mres      = r_mres;
        n_m         = r_m;
        n_pass      = r_pass;
        n_perm      = r_perm;
        n_row       = r_row;
        n_bit       = r_bit;
        n_mop       = r_mop;
        n_macc      = r_macc;
        n_prod      = r_prod;
        n_det       = r_det;
        n_den       = r_den;
        n_zero      = r_zero;
        n_status    = r_status;
        n_eidx      = r_eidx;
        n_out_valid = m_axis_tready ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last = s_axis_tlast;
                    if (cnt_room) begin
                        n_x     = r_swap ? in_second : in_first;
                        n_y     = r_swap ? in_first : in_second;
                        n_p     = VALUE_BITS'(1);
                        n_k     = '0;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_ACC_PS: begin
                n_psum[r_k] = r_psum[r_k] + r_p;
                n_mres      = mul_full[VALUE_BITS-1:0];
            end
            S_ACC_P: begin
                if (r_k < PS_AW'(NCOEF)) begin
                    n_csum[cr_addr] = r_csum[cr_addr] + r_mres;
                end
                n_p = mul_full[VALUE_BITS-1:0];
                n_k = r_k + PS_AW'(1);
            end
            S_SOLVE: begin
                n_m    = ROW_W'(d_eff) + ROW_W'(1);
                n_pass = '0;
                n_eidx = '0;
                n_zero = few;
                n_status = ST_FEW;
            end
            S_DET_START: begin
                n_det  = '0;
                n_perm = '0;
            end
            S_PERM: begin
                if (perm_ok) begin
                    n_prod = BIG_W'(1);
                    n_row  = '0;
                end else if (!perm_end) begin
                    n_perm = r_perm + PERM_W'(1);
                end
            end
            S_ROW: begin
                if (!row_end) begin
                    n_mop  = entry;
                    n_macc = '0;
                    n_bit  = BIT_W'(VALUE_BITS - 1);
                end else begin
                    n_det = PERM_ODD[r_perm] ? (r_det - r_prod) : (r_det + r_prod);
                    if (!perm_end) begin
                        n_perm = r_perm + PERM_W'(1);
                    end
                end
            end
            S_MUL: begin
                n_macc = {r_macc[BIG_W-2:0], 1'b0} + mul_add;
                if (r_bit == '0) begin
                    n_prod = n_macc;
                    n_row  = r_row + ROW_W'(1);
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_DET_END: begin
                if (r_pass == '0) begin
                    if (r_det == '0) begin
                        n_zero   = 1'b1;
                        n_status = ST_SINGULAR;
                    end else begin
                        n_den  = r_det;
                        n_pass = ROW_W'(1);
                    end
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (r_pass == r_m) begin
                        n_status = r_ovf ? ST_OVERFLOW : ST_OK;
                    end else begin
                        n_pass = r_pass + ROW_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0,
                                   (r_zero ? VALUE_BITS'(0) : r_coef[r_eidx[CR_AW-1:0]]),
                                   2'(r_eidx)};
                    n_out_last  = emit_last;
                    n_out_user  = r_status;
                    n_eidx      = r_eidx + ROW_W'(1);
                    if (emit_last) begin
                        for (int i = 0; i < NPOW; i++) begin
                            n_psum[i] = '0;
                        end
                        for (int i = 0; i < NCOEF; i++) begin
                            n_csum[i] = '0;
                        end
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_degree    <= DEGREE_RESET;
            r_swap      <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NPOW; i++) begin
                r_psum[i] <= '0;
            end
            for (int i = 0; i < NCOEF; i++) begin
                r_csum[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_psum      <= n_psum;
            r_csum      <= n_csum;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DEGREE: r_degree <= i_cfg_data;
                    CFG_SWAP:   r_swap   <= i_cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_last     <= n_last;
        r_k        <= n_k;
        r_p        <= n_p;
        r_mres     <= n_mres;
        r_m        <= n_m;
        r_pass     <= n_pass;
        r_perm     <= n_perm;
        r_row      <= n_row;
        r_bit      <= n_bit;
        r_mop      <= n_mop;
        r_macc     <= n_macc;
        r_prod     <= n_prod;
        r_det      <= n_det;
        r_den      <= n_den;
        r_zero     <= n_zero;
        r_status   <= n_status;
        r_eidx     <= n_eidx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
        if (coef_we) begin
            r_coef[pass_m1[CR_AW-1:0]] <= div_res.value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FEW || m_axis_tuser == ST_SINGULAR)
        |-> m_axis_tdata[65:2] == '0)
        else $error("failed fit carries a nonzero coefficient");

    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CNT_W'(MAX_POINTS))
        else $error("overflow flag set below the point limit");

    a_emit_solved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && !r_zero |-> r_pass == r_m)
        else $error("coefficient sent before all determinants were solved");

endmodule

/* tb/least_squares_polyfit_checker.sv */
// Checker for the polynomial fit block: predicts coefficients and compares each result.
module least_squares_polyfit_checker
    import lsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pt_valid,
    input  logic        i_pt_ready,
    input  logic [23:0] i_pt_data,
    input  logic        i_pt_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [71:0] i_res_data,
    input  logic        i_res_last,
    input  logic [1:0]  i_res_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int NPOW = 5;
    localparam int NCOEF = 3;
    localparam int POINT_LIMIT = 1024;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic [1:0]  index;
        logic [63:0] value;
        logic        last;
        t_fit_status status;
    } t_coeff;

    t_coeff      coeff_q[$];
    logic [63:0] pow_sum [NPOW];
    logic [63:0] xy_sum [NCOEF];
    int          pt_count;
    logic        pt_overflow;
    logic [1:0]  fit_degree;
    logic        swap_xy;
    int          mismatches;

    function automatic t_wide det_of(t_wide mt [NCOEF][NCOEF], int n);
        if (n == 2) begin
            return mt[0][0] * mt[1][1] - mt[0][1] * mt[1][0];
        end
        return mt[0][0] * (mt[1][1] * mt[2][2] - mt[1][2] * mt[2][1])
             - mt[0][1] * (mt[1][0] * mt[2][2] - mt[1][2] * mt[2][0])
             + mt[0][2] * (mt[1][0] * mt[2][1] - mt[1][1] * mt[2][0]);
    endfunction

    function automatic logic [63:0] q32_quotient(t_wide num, t_wide den);
        logic         neg;
        logic [319:0] n_abs;
        logic [319:0] d_abs;
        logic [319:0] q;
        neg   = (num < 0) != (den < 0);
        n_abs = (num < 0) ? 320'(-num) : 320'(num);
        d_abs = (den < 0) ? 320'(-den) : 320'(den);
        q     = ((n_abs << 33) + d_abs) / (d_abs << 1);
        if (!neg) begin
            return (q > 320'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
        end
        if (q > 320'h8000_0000_0000_0000) begin
            return 64'h8000_0000_0000_0000;
        end
        return 64'(0) - q[63:0];
    endfunction

    task automatic predict_fit();
        int          d;
        t_wide       sys [NCOEF][NCOEF];
        t_wide       mt [NCOEF][NCOEF];
        t_wide       det;
        logic [63:0] coef [NCOEF];
        t_fit_status status;
        t_coeff      c;
        d = (fit_degree == 0) ? 1 : (fit_degree > 2 ? 2 : int'(fit_degree));
        status = ST_OK;
        for (int k = 0; k < NCOEF; k++) coef[k] = '0;
        for (int i = 0; i < NCOEF; i++)
            for (int j = 0; j < NCOEF; j++)
                sys[i][j] = (i <= d && j <= d) ? t_wide'($signed(pow_sum[i + j])) : '0;
        if (pt_count <= d) begin
            status = ST_FEW;
        end else begin
            det = det_of(sys, d + 1);
            if (det == 0) begin
                status = ST_SINGULAR;
            end else begin
                for (int k = 0; k <= d; k++) begin
                    mt = sys;
                    for (int i = 0; i <= d; i++) mt[i][k] = t_wide'($signed(xy_sum[i]));
                    coef[k] = q32_quotient(det_of(mt, d + 1), det);
                end
                if (pt_overflow) status = ST_OVERFLOW;
            end
        end
        for (int k = 0; k <= d; k++) begin
            c.index  = 2'(k);
            c.value  = coef[k];
            c.last   = (k == d);
            c.status = status;
            coeff_q  = {coeff_q, c};
        end
    endtask

    task automatic add_point(logic [23:0] data);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] p;
        x = swap_xy ? 64'($signed(data[23:12])) : 64'($signed(data[11:0]));
        y = swap_xy ? 64'($signed(data[11:0])) : 64'($signed(data[23:12]));
        if (pt_count < POINT_LIMIT) begin
            p = 64'd1;
            for (int k = 0; k < NPOW; k++) begin
                pow_sum[k] += p;
                if (k < NCOEF) xy_sum[k] += p * y;
                p *= x;
            end
            pt_count++;
        end else begin
            pt_overflow = 1'b1;
        end
    endtask

    task automatic clear_sums();
        for (int k = 0; k < NPOW; k++) pow_sum[k] = '0;
        for (int k = 0; k < NCOEF; k++) xy_sum[k] = '0;
        pt_count    = 0;
        pt_overflow = 1'b0;
    endtask

    initial begin
        mismatches = 0;
        o_errors   = 0;
        o_pending  = 0;
        o_checked  = 0;
        fit_degree = DEGREE_RESET;
        swap_xy    = 1'b0;
        clear_sums();
    end

    always @(posedge i_clk) begin
        t_coeff c;
        if (!i_rst_n) begin
            clear_sums();
            fit_degree = DEGREE_RESET;
            swap_xy    = 1'b0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                o_checked <= o_checked + 1;
                if (coeff_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected coefficient transaction %h", i_res_data);
                end else begin
                    c = coeff_q.pop_front();
                    if (i_res_data[1:0] !== c.index || i_res_data[65:2] !== c.value
                            || i_res_last !== c.last || i_res_user !== c.status
                            || i_res_data[71:66] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: coeff exp idx %0d val %h last %b st %0d,",
                                     c.index, c.value, c.last, c.status,
                                     " got idx %0d val %h last %b st %0d",
                                     i_res_data[1:0], i_res_data[65:2], i_res_last,
                                     i_res_user);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DEGREE) fit_degree = i_cfg_data;
                else swap_xy = i_cfg_data[0];
            end
            if (i_pt_valid && i_pt_ready) begin
                add_point(i_pt_data);
                if (i_pt_last) begin
                    predict_fit();
                    clear_sums();
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= coeff_q.size();
    end

endmodule

/* tb/least_squares_polyfit_tb.sv */
// Testbench top for the polynomial fit block: stimulus, stalls, watchdog and verdict.
module least_squares_polyfit_tb;
    import lsp_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [1:0]  i_cfg_data = '0;

    int   errors;
    int   pending;
    int   checked;
    int   idle_cycles = 0;
    int   points_sent = 0;
    int   sets_sent = 0;
    logic no_stall = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    least_squares_polyfit i_dut (.*);

    least_squares_polyfit_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pt_valid(s_axis_tvalid), .i_pt_ready(s_axis_tready),
        .i_pt_data(s_axis_tdata), .i_pt_last(s_axis_tlast),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_last(m_axis_tlast), .i_res_user(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int gap;
        forever begin
            gap = no_stall ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_point(logic [11:0] first, logic [11:0] second, logic last);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second, first};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        points_sent++;
        if (last) sets_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_set(int size, int mode);
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] fixed;
        fixed = 12'($urandom);
        for (int i = 0; i < size; i++) begin
            a = 12'($urandom);
            b = 12'($urandom);
            if (mode == 1) begin
                a = 12'($signed($urandom_range(0, 15)) - 8);
                b = 12'($signed($urandom_range(0, 15)) - 8);
            end else if (mode == 2) begin
                a = fixed;
            end
            send_point(a, b, i == size - 1);
        end
    endtask

    initial begin
        int size;
        int mode;
        int random_points;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(12'h800, 12'h800, 1'b0);
        send_point(12'h7FF, 12'h7FF, 1'b0);
        send_point(12'd0, 12'd5, 1'b1);
        send_point(12'd3, 12'h800, 1'b0);
        send_point(12'd9, 12'h7FF, 1'b1);
        send_point(12'd100, 12'd1, 1'b0);
        send_point(12'd100, 12'd2, 1'b0);
        send_point(12'd100, 12'hFFD, 1'b1);
        drain();
        write_reg(CFG_DEGREE, 2'd1);
        write_reg(CFG_SWAP, 2'd1);
        send_point(12'h800, 12'h7FF, 1'b0);
        send_point(12'h7FF, 12'h800, 1'b1);
        send_point(12'd7, 12'd7, 1'b1);
        drain();
        write_reg(CFG_DEGREE, 2'd0);
        write_reg(CFG_SWAP, 2'd2);
        send_point(12'd1, 12'd2, 1'b1);
        send_point(12'd1, 12'd2, 1'b0);
        send_point(12'd4, 12'hFF0, 1'b1);
        drain();
        write_reg(CFG_DEGREE, 2'd3);
        random_set(4, 0);
        random_set(2, 1);
        drain();

        // Overfull set: points past the limit are dropped.
        write_reg(CFG_DEGREE, 2'd2);
        no_stall = 1'b1;
        random_set(1030, 0);
        drain();
        no_stall = 1'b0;

        random_points = 0;
        while (random_points < 380) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                if ($urandom_range(0, 1)) write_reg(CFG_DEGREE, 2'($urandom));
                if ($urandom_range(0, 1)) write_reg(CFG_SWAP, 2'($urandom));
            end
            no_stall = ($urandom_range(0, 4) == 0);
            mode = $urandom_range(0, 9);
            mode = (mode < 6) ? 0 : (mode < 9 ? 1 : 2);
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            random_set(size, mode);
            random_points += size;
        end
        no_stall = 1'b0;
        drain();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d points in %0d sets with an overfull set; checked %0d coefficients.",
                 points_sent, sets_sent, checked);
        $display("Covered degrees 0 to 3, both axis orders, singular and short sets.");
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/lsp_pkg.sv
rtl/lsp_qdiv.sv
rtl/least_squares_polyfit.sv
tb/least_squares_polyfit_checker.sv
tb/least_squares_polyfit_tb.sv
